@@ rtl/cdq_pkg.sv @@
// Package for the circular deque: item payload types, operation codes
// and the control bundle that the top level hands to every storage cell.
// No dependencies.
package cdq_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned KIND_WIDTH  = 3;
  localparam int unsigned CAP_WIDTH   = 5;

  typedef logic signed [VALUE_WIDTH-1:0] cdq_value_t;
  typedef logic [KIND_WIDTH-1:0]         cdq_kind_t;
  typedef logic [CAP_WIDTH-1:0]          cdq_cap_t;

  // Operation codes carried in the kind field
  localparam cdq_kind_t KIND_PUSH_FRONT = 3'd0;
  localparam cdq_kind_t KIND_PUSH_REAR  = 3'd1;
  localparam cdq_kind_t KIND_POP_FRONT  = 3'd2;
  localparam cdq_kind_t KIND_POP_REAR   = 3'd3;
  localparam cdq_kind_t KIND_PEEK       = 3'd4;

  localparam cdq_cap_t CAP_RESET = 5'd16;

  // Input item
  typedef struct packed {
    cdq_kind_t  kind;
    cdq_value_t value;
  } cdq_in_t;

  // Result item
  typedef struct packed {
    logic       ok;
    cdq_value_t front_value;
    cdq_value_t rear_value;
    logic       is_empty;
    logic       is_full;
  } cdq_out_t;

  // Per-cycle command broadcast to the row of cells
  typedef struct packed {
    logic       push_front;
    logic       pop_front;
    logic       push_rear;
    cdq_value_t value;
  } cdq_cell_ctrl_t;

endpackage

@@ rtl/cdq_cell.sv @@
// One storage cell of the deque row: holds one entry and trades it with
// its neighbors on front pushes and pops. Depends on cdq_pkg.
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic           clk_i,
  input  cdq_cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]  wr_idx_i,
  input  logic [CW-1:0]  rear_idx_i,
  input  cdq_value_t     left_i,
  input  cdq_value_t     right_i,
  input  cdq_value_t     rear_i,
  output cdq_value_t     data_o,
  output cdq_value_t     rear_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  cdq_value_t data_q, data_d;

  // Pick the next entry: shift toward the rear, shift toward the front, or load
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_front) begin
      data_d = (IDX == 0) ? ctrl_i.value : left_i;
    end else if (ctrl_i.pop_front) begin
      data_d = right_i;
    end else if (ctrl_i.push_rear && (wr_idx_i == MyIdx)) begin
      data_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Merge this entry into the rear read chain when it is the rear slot
  assign rear_o = rear_i | ((rear_idx_i == MyIdx) ? data_q : '0);
  assign data_o = data_q;

endmodule

@@ rtl/circular_deque_top.sv @@
// Circular deque: bounded double-ended queue built as a row of cells with
// the front entry in cell 0. The result is valid in the cycle after the
// item is accepted. Throughput: one item per cycle, a new item is taken
// in the cycle its predecessor's result is taken; the rear read chain
// through all cells sets the cycle time. Reset clears count and handshake
// state and sets capacity to 16; cell contents are not reset.
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  cdq_cap_t cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cdq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cdq_out_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned EW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

  cdq_cap_t       cap_q;
  logic [CW-1:0]  count_q, count_d;
  logic           out_valid_q;
  logic           ok_q, ok_d;
  logic [CW-1:0]  cap_eff;
  logic [EW-1:0]  cap_ext;
  logic           full, empty, accept;
  logic [CW-1:0]  rear_idx;
  cdq_cell_ctrl_t ctrl;

  cdq_value_t cell_data [MAX_CAPACITY];
  cdq_value_t rear_chain [MAX_CAPACITY+1];

  // Clamp the capacity register into 1..MAX_CAPACITY
  assign cap_ext = EW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(MAX_CAPACITY)) begin
      cap_eff = CW'(MAX_CAPACITY);
    end else begin
      cap_eff = CW'(cap_ext);
    end
  end

  assign full       = (count_q >= cap_eff);
  assign empty      = (count_q == '0);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the operation into a cell command and the next count
  always_comb begin
    ctrl       = '0;
    ctrl.value = in_data_i.value;
    count_d    = count_q;
    ok_d       = 1'b0;
    case (in_data_i.kind)
      KIND_PUSH_FRONT: begin
        if (!full) begin
          ctrl.push_front = accept;
          count_d         = count_q + CW'(1);
          ok_d            = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (!full) begin
          ctrl.push_rear = accept;
          count_d        = count_q + CW'(1);
          ok_d           = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (!empty) begin
          ctrl.pop_front = accept;
          count_d        = count_q - CW'(1);
          ok_d           = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (!empty) begin
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      KIND_PEEK: begin
        ok_d = !empty;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Hold capacity, count and the pending result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        count_q <= '0;
      end else if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
        ok_q        <= ok_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Row of storage cells, front entry in cell 0
  assign rear_idx      = count_q - CW'(1);
  assign rear_chain[0] = '0;

  for (genvar i = 0; i < MAX_CAPACITY; i++) begin : g_cell
    cdq_value_t left_nb, right_nb;
    if (i == 0) begin : g_first
      assign left_nb = cell_data[0];
    end else begin : g_mid_l
      assign left_nb = cell_data[i-1];
    end
    if (i == MAX_CAPACITY - 1) begin : g_last
      assign right_nb = cell_data[i];
    end else begin : g_mid_r
      assign right_nb = cell_data[i+1];
    end
    cdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .wr_idx_i   (count_q),
      .rear_idx_i (rear_idx),
      .left_i     (left_nb),
      .right_i    (right_nb),
      .rear_i     (rear_chain[i]),
      .data_o     (cell_data[i]),
      .rear_o     (rear_chain[i+1])
    );
  end

  // Report the deque as it stands after the last accepted item
  assign out_valid_o            = out_valid_q;
  assign out_data_o.ok          = ok_q;
  assign out_data_o.front_value = empty ? '1 : cell_data[0];
  assign out_data_o.rear_value  = empty ? '1 : rear_chain[MAX_CAPACITY];
  assign out_data_o.is_empty    = empty;
  assign out_data_o.is_full     = full;

endmodule
